// ===== rtl/apcs_pkg.sv =====
// apcs_pkg: shared constants and codes for the ADC phase current / PT100 scaler.
// No dependencies; imported by adc_phase_current_pt100_scaler.
package apcs_pkg;

  // ADC resolution and the divider full-scale value
  localparam int ADC_BITS   = 12;
  localparam int FULL_SCALE = 1 << ADC_BITS;

  // divider upper voltage <= 1 mV  <=>  d * 3300 <= FULL_SCALE  <=>  d <= CLAMP_D
  localparam int CLAMP_D     = FULL_SCALE / 3300;
  localparam int CLAMP_CENTI = 20000;

  // centi-degC = (5*raw - 2*F) * TEMP_SCALE / (DEN_MUL * (F - raw)), rounded
  localparam int TEMP_SCALE = 1000000;
  localparam int DEN_MUL    = 77;

  localparam int CUR_LIMIT = 300000;

  // field widths
  localparam int CUR_W  = 20;
  localparam int CURC_W = 21;
  localparam int VB_W   = 20;
  localparam int TEMP_W = 28;

  // temperature datapath widths
  localparam int TS_W  = 15;  // 5*raw - 2F, signed
  localparam int TM_W  = 14;  // magnitude of the above
  localparam int TN_W  = 34;  // rounded numerator magnitude
  localparam int DEN_W = 19;  // 77 * d
  localparam int QW    = 27;  // quotient bits

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MID_CODE  = 3'd0,
    CFG_CUR_GAIN  = 3'd1,
    CFG_OFFSET_A  = 3'd2,
    CFG_OFFSET_B  = 3'd3,
    CFG_VBUS_GAIN = 3'd4
  } cfg_idx_t;

  // reset values
  localparam logic [11:0] MID_CODE_RST  = 12'd2048;
  localparam logic [15:0] CUR_GAIN_RST  = 16'd10317;
  localparam logic [15:0] OFFSET_A_RST  = 16'd1040;
  localparam logic [15:0] OFFSET_B_RST  = 16'd240;
  localparam logic [15:0] VBUS_GAIN_RST = 16'd4744;

endpackage

// ===== rtl/adc_phase_current_pt100_scaler.sv =====
// adc_phase_current_pt100_scaler: converts one set of injected ADC codes per beat
// to phase currents, bus voltage and PT100 temperature. Depends on apcs_pkg.
//
//  port group | dir | contents (lowest bit first)
//  -----------+-----+-----------------------------------------------------------
//  in_*       | in  | tdata: vbus_raw, temp_raw, ia_raw, ib_raw (12 b each)
//  out_*      | out | tdata: current_a/b/c_ma, vbus_mv, temp_centi_c; tuser: clamp
//  cfg_*      | in  | write-only: mid_code, current_gain_q8, offset_a/b, vbus_gain
//
// One beat is taken per cycle while out_tready is high. Most of the depth comes from the
// temperature divider: 27 restoring stages, one quotient bit each, after three
// stages of products, rounding and saturation, plus a final sign/clamp stage.
// rst_n (sync, active low) empties the pipe and restores register defaults.
// Each stage loads whenever out_tready is high or it or any stage downstream is
// empty, so bubbles close up under an output stall and a beat is never dropped or repeated.
module adc_phase_current_pt100_scaler (
  input  logic                             clk,
  input  logic                             rst_n,
  // slave side
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [apcs_pkg::IN_TDATA_W-1:0]  in_tdata,   // vbus_raw, temp_raw, ia_raw, ib_raw
  // master side
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [apcs_pkg::OUT_TDATA_W-1:0] out_tdata,  // ia, ib, ic, vbus_mv, temp, pad
  output logic                             out_tuser,  // temp_clamped
  // configuration
  input  logic                             cfg_we,
  input  logic [apcs_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [apcs_pkg::CFG_DW-1:0]      cfg_wdata
);
  import apcs_pkg::*;

  localparam int DIV_FIRST = 3;               // first divider stage
  localparam int LAST      = DIV_FIRST + QW;  // output stage
  localparam int NST       = LAST + 1;
  localparam logic [NST-1:0] ONE = NST'(1);

  // ---------------- configuration registers
  logic        [11:0] mid_code_r;
  logic        [15:0] cur_gain_r;
  logic signed [15:0] offset_a_r;
  logic signed [15:0] offset_b_r;
  logic        [15:0] vbus_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_code_r  <= MID_CODE_RST;
      cur_gain_r  <= CUR_GAIN_RST;
      offset_a_r  <= OFFSET_A_RST;
      offset_b_r  <= OFFSET_B_RST;
      vbus_gain_r <= VBUS_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MID_CODE:  mid_code_r  <= cfg_wdata[11:0];
        CFG_CUR_GAIN:  cur_gain_r  <= cfg_wdata;
        CFG_OFFSET_A:  offset_a_r  <= cfg_wdata;
        CFG_OFFSET_B:  offset_b_r  <= cfg_wdata;
        CFG_VBUS_GAIN: vbus_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] en;

  // stage k loads if out_tready, or if any stage from k up is empty
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      en[k] = out_tready | ~(&(v_r | ((ONE << k) - ONE)));
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[LAST];

  // ---------------- stage 0: offsets removed, products
  logic [11:0] vraw, traw, iaraw, ibraw;
  assign vraw  = in_tdata[11:0];
  assign traw  = in_tdata[23:12];
  assign iaraw = in_tdata[35:24];
  assign ibraw = in_tdata[47:36];

  logic signed [12:0] da_nxt, db_nxt;
  logic signed [29:0] pa_nxt, pb_nxt;
  logic        [27:0] pv_nxt;
  logic        [TS_W-1:0] t5;
  logic signed [TS_W-1:0] ts_nxt;
  logic        [12:0] td_nxt;
  logic               tcl_nxt;

  always_comb begin
    da_nxt  = $signed({1'b0, iaraw}) - $signed({1'b0, mid_code_r});
    db_nxt  = $signed({1'b0, ibraw}) - $signed({1'b0, mid_code_r});
    pa_nxt  = 30'(da_nxt) * $signed({14'd0, cur_gain_r});
    pb_nxt  = 30'(db_nxt) * $signed({14'd0, cur_gain_r});
    pv_nxt  = 28'(vraw) * 28'(vbus_gain_r);
    t5      = TS_W'(traw) * TS_W'(5);
    ts_nxt  = $signed(t5 - TS_W'(2 * FULL_SCALE));
    td_nxt  = 13'(FULL_SCALE) - {1'b0, traw};
    tcl_nxt = (td_nxt <= 13'(CLAMP_D));
  end

  logic signed [29:0]     pa_r, pb_r;
  logic        [27:0]     pv_r;
  logic signed [TS_W-1:0] ts_r;
  logic        [12:0]     td_r;
  logic                   tcl_r [0:LAST];

  // ---------------- stage 1: Q8 rounding, offsets, temperature numerator/denominator
  logic signed [29:0]     pa_rnd, pb_rnd;
  logic signed [21:0]     sa_nxt, sb_nxt;
  logic        [27:0]     vsum;
  logic        [TM_W-1:0] tmag;
  logic        [TN_W-1:0] tnum_nxt;
  logic        [DEN_W-1:0] tden_nxt;

  always_comb begin
    pa_rnd   = pa_r + 30'sd128;
    pb_rnd   = pb_r + 30'sd128;
    sa_nxt   = $signed(pa_rnd[29:8]) + 22'(offset_a_r);
    sb_nxt   = $signed(pb_rnd[29:8]) + 22'(offset_b_r);
    // max sum stays below 2^28, so the 1048575 mV ceiling is never reached
    vsum     = pv_r + 28'd128;
    tmag     = ts_r[TS_W-1] ? TM_W'(-ts_r) : ts_r[TM_W-1:0];
    tnum_nxt = TN_W'(tmag) * TN_W'(TEMP_SCALE);
    tden_nxt = DEN_W'(td_r) * DEN_W'(DEN_MUL);
  end

  logic signed [21:0]      sa_r, sb_r;
  logic        [VB_W-1:0]  vb_r   [1:LAST];
  logic        [TN_W-1:0]  tnum_r;
  logic        [DEN_W-1:0] tden_r [1:LAST-2];
  logic                    tneg_r [1:LAST-1];

  // ---------------- stage 2: saturation, rounding bias on the numerator
  function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [21:0] v);
    if (v > 22'sd300000) begin
      sat_cur = CUR_W'(CUR_LIMIT);
    end else if (v < -22'sd300000) begin
      sat_cur = CUR_W'(-CUR_LIMIT);
    end else begin
      sat_cur = v[CUR_W-1:0];
    end
  endfunction

  logic [TN_W-1:0] tn_nxt;
  assign tn_nxt = tnum_r + TN_W'(tden_r[1] >> 1);

  logic signed [CUR_W-1:0]  ca_r [2:LAST];
  logic signed [CUR_W-1:0]  cb_r [2:LAST];
  logic        [TN_W-1:0]   tn_r;

  // ---------------- stage 3: phase C; stages 3..LAST-1: restoring divider
  logic signed [CURC_W-1:0] cc_nxt;
  assign cc_nxt = -(CURC_W'(ca_r[2]) + CURC_W'(cb_r[2]));

  logic signed [CURC_W-1:0] cc_r [DIV_FIRST:LAST];

  logic [DEN_W-1:0] rem_in  [DIV_FIRST:LAST-1];
  logic [QW-1:0]    x_in    [DIV_FIRST:LAST-1];
  logic [DEN_W:0]   dv_t    [DIV_FIRST:LAST-1];
  logic             dv_ge   [DIV_FIRST:LAST-1];
  logic [DEN_W-1:0] rem_nxt [DIV_FIRST:LAST-1];
  logic [QW-1:0]    x_nxt   [DIV_FIRST:LAST-1];
  logic [DEN_W-1:0] rem_r   [DIV_FIRST:LAST-2];
  logic [QW-1:0]    x_r     [DIV_FIRST:LAST-1];

  // top bits of the numerator are already below the smallest divisor of an unclamped sample
  always_comb begin
    rem_in[DIV_FIRST] = DEN_W'(tn_r[TN_W-1:QW]);
    x_in[DIV_FIRST]   = tn_r[QW-1:0];
    for (int k = DIV_FIRST + 1; k < LAST; k++) begin
      rem_in[k] = rem_r[k-1];
      x_in[k]   = x_r[k-1];
    end
    for (int k = DIV_FIRST; k < LAST; k++) begin
      dv_t[k]    = {rem_in[k], x_in[k][QW-1]};
      dv_ge[k]   = dv_t[k] >= {1'b0, tden_r[k-1]};
      rem_nxt[k] = dv_ge[k] ? DEN_W'(dv_t[k] - {1'b0, tden_r[k-1]}) : dv_t[k][DEN_W-1:0];
      x_nxt[k]   = {x_in[k][QW-2:0], dv_ge[k]};
    end
  end

  // ---------------- output stage: sign and full-scale substitution
  logic signed [TEMP_W-1:0] temp_nxt;
  logic signed [TEMP_W-1:0] temp_r;

  always_comb begin
    if (tcl_r[LAST-1]) begin
      temp_nxt = TEMP_W'(CLAMP_CENTI);
    end else if (tneg_r[LAST-1]) begin
      temp_nxt = -$signed({1'b0, x_r[LAST-1]});
    end else begin
      temp_nxt = $signed({1'b0, x_r[LAST-1]});
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      pv_r     <= pv_nxt;
      ts_r     <= ts_nxt;
      td_r     <= td_nxt;
      tcl_r[0] <= tcl_nxt;
    end
    if (en[1]) begin
      sa_r      <= sa_nxt;
      sb_r      <= sb_nxt;
      vb_r[1]   <= vsum[27:8];
      tnum_r    <= tnum_nxt;
      tden_r[1] <= tden_nxt;
      tneg_r[1] <= ts_r[TS_W-1];
      tcl_r[1]  <= tcl_r[0];
    end
    if (en[2]) begin
      ca_r[2]   <= sat_cur(sa_r);
      cb_r[2]   <= sat_cur(sb_r);
      vb_r[2]   <= vb_r[1];
      tn_r      <= tn_nxt;
      tden_r[2] <= tden_r[1];
      tneg_r[2] <= tneg_r[1];
      tcl_r[2]  <= tcl_r[1];
    end
    if (en[DIV_FIRST]) begin
      cc_r[DIV_FIRST] <= cc_nxt;
    end
    for (int k = DIV_FIRST + 1; k <= LAST; k++) begin
      if (en[k]) begin
        cc_r[k] <= cc_r[k-1];
      end
    end
    for (int k = DIV_FIRST; k <= LAST; k++) begin
      if (en[k]) begin
        ca_r[k]  <= ca_r[k-1];
        cb_r[k]  <= cb_r[k-1];
        vb_r[k]  <= vb_r[k-1];
        tcl_r[k] <= tcl_r[k-1];
      end
    end
    for (int k = DIV_FIRST; k < LAST; k++) begin
      if (en[k]) begin
        x_r[k]    <= x_nxt[k];
        tneg_r[k] <= tneg_r[k-1];
      end
    end
    for (int k = DIV_FIRST; k <= LAST - 2; k++) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt[k];
        tden_r[k] <= tden_r[k-1];
      end
    end
    if (en[LAST]) begin
      temp_r <= temp_nxt;
    end
  end

  assign out_tdata = {3'b000, temp_r, vb_r[LAST], cc_r[LAST], cb_r[LAST], ca_r[LAST]};
  assign out_tuser = tcl_r[LAST];

endmodule
